@@ rtl/stwa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwa_pkg
// Types, constants and helpers shared by the station table with aging.
// ----------------------------------------------------------------------------
package stwa_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  localparam logic [1:0] REQ_FIND_CREATE = 2'd0;
  localparam logic [1:0] REQ_FIND_ID     = 2'd1;
  localparam logic [1:0] REQ_PRUNE       = 2'd2;
  localparam logic [1:0] REQ_LIST        = 2'd3;

  localparam logic [3:0] ST_FOUND      = 4'd0;
  localparam logic [3:0] ST_RENAMED    = 4'd1;
  localparam logic [3:0] ST_CREATED    = 4'd2;
  localparam logic [3:0] ST_BAD_ID     = 4'd3;
  localparam logic [3:0] ST_ID_TAKEN   = 4'd4;
  localparam logic [3:0] ST_FULL       = 4'd5;
  localparam logic [3:0] ST_NONE       = 4'd6;
  localparam logic [3:0] ST_TIMED_OUT  = 4'd7;
  localparam logic [3:0] ST_PRUNE_DONE = 4'd8;
  localparam logic [3:0] ST_LIST_ENTRY = 4'd9;
  localparam logic [3:0] ST_LIST_EMPTY = 4'd10;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_MIN_ID  = 2'd1;
  localparam logic [1:0] CFG_MAX_ID  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] station_mac;
    logic [7:0]  station_id;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  slot;
    logic [7:0]  result_id;
    logic [47:0] result_mac;
    logic [4:0]  active_count;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  node_id;
    logic [47:0] mac;
    logic [31:0] created;
  } entry_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [TABLE_SLOTS-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ rtl/station_table_with_aging_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// station_table_with_aging_core
// Station table in a synchronous memory, scanned slot by slot per request.
// ----------------------------------------------------------------------------
// Lookup, create and prune requests scan every slot, then give the final
// result; prune reports each timed-out entry as it is scanned.
// A list request makes one full memory scan per listed node, as the
// memory has a single read port.
// Reset empties the table and loads the register defaults; the receiver
// cannot stall, results appear for one cycle with out_valid.
module station_table_with_aging_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  stwa_pkg::req_t     in_req,
  output logic               out_valid,
  output stwa_pkg::rsp_t     out_rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import stwa_pkg::*;

  entry_t mem [TABLE_SLOTS];

  fsm_t                   state_r, state_nxt;
  req_t                   req_r, req_nxt;
  logic [TABLE_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [CNT_W-1:0]       rd_cnt_r, rd_cnt_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  logic [SLOT_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  entry_t                 rd_data_r;
  logic                   hit_v_r, hit_v_nxt;
  logic [SLOT_W-1:0]      hit_idx_r, hit_idx_nxt;
  entry_t                 hit_ent_r, hit_ent_nxt;
  logic                   taken_r, taken_nxt;
  logic                   prev_v_r, prev_v_nxt;
  logic [SLOT_W+7:0]      prev_key_r, prev_key_nxt;
  logic [CNT_W-1:0]       emitted_r, emitted_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rsp_t                   out_r, out_nxt;
  logic [31:0]            timeout_r;
  logic [7:0]             min_id_r, max_id_r;

  logic                   rd_en, wr_en;
  logic [SLOT_W-1:0]      rd_addr, wr_addr;
  entry_t                 wr_data;
  logic                   id_ok, free_v, u;
  logic [SLOT_W-1:0]      free_idx;
  logic [SLOT_W+7:0]      key, best_key;
  logic [CNT_W-1:0]       total;
  logic [3:0]             st;

  assign busy      = (state_r != FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;
  assign cfg_ready = 1'b1;

  assign id_ok    = (req_r.station_id >= min_id_r) && (req_r.station_id <= max_id_r);
  assign total    = popcount(in_use_r);
  assign u        = in_use_r[cmp_idx_r];
  assign key      = {rd_data_r.node_id, cmp_idx_r};
  assign best_key = {hit_ent_r.node_id, hit_idx_r};

  always_comb begin
    free_v   = 1'b0;
    free_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_v   = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    in_use_nxt    = in_use_r;
    rd_cnt_nxt    = rd_cnt_r;
    cmp_v_nxt     = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    hit_v_nxt     = hit_v_r;
    hit_idx_nxt   = hit_idx_r;
    hit_ent_nxt   = hit_ent_r;
    taken_nxt     = taken_r;
    prev_v_nxt    = prev_v_r;
    prev_key_nxt  = prev_key_r;
    emitted_nxt   = emitted_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = rd_cnt_r[SLOT_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = hit_idx_r;
    wr_data       = '{node_id: req_r.station_id, mac: hit_ent_r.mac,
                      created: hit_ent_r.created};
    st            = ST_FOUND;

    unique case (state_r)
      FSM_IDLE: begin
        if (start) begin
          req_nxt     = in_req;
          state_nxt   = FSM_SCAN;
          rd_cnt_nxt  = '0;
          hit_v_nxt   = 1'b0;
          taken_nxt   = 1'b0;
          prev_v_nxt  = 1'b0;
          emitted_nxt = '0;
        end
      end

      FSM_SCAN: begin
        if (rd_cnt_r < CNT_W'(TABLE_SLOTS)) begin
          rd_en       = 1'b1;
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = rd_cnt_r[SLOT_W-1:0];
        end
        if (cmp_v_r && u) begin
          unique case (req_r.req_type)
            REQ_FIND_CREATE: begin
              if (!hit_v_r && rd_data_r.mac == req_r.station_mac) begin
                hit_v_nxt   = 1'b1;
                hit_idx_nxt = cmp_idx_r;
                hit_ent_nxt = rd_data_r;
              end
              if (rd_data_r.node_id == req_r.station_id) taken_nxt = 1'b1;
            end
            REQ_FIND_ID: begin
              if (!hit_v_r && rd_data_r.node_id == req_r.station_id) begin
                hit_v_nxt   = 1'b1;
                hit_idx_nxt = cmp_idx_r;
                hit_ent_nxt = rd_data_r;
              end
            end
            REQ_PRUNE: begin
              if ((req_r.now_time - rd_data_r.created) > timeout_r) begin
                in_use_nxt[cmp_idx_r] = 1'b0;
                out_valid_nxt = 1'b1;
                out_nxt = '{status: ST_TIMED_OUT, slot: 4'(cmp_idx_r),
                            result_id: rd_data_r.node_id, result_mac: rd_data_r.mac,
                            active_count: 5'(popcount(in_use_nxt)), last: 1'b0};
              end
            end
            REQ_LIST: begin
              if ((!prev_v_r || key > prev_key_r) && (!hit_v_r || key < best_key)) begin
                hit_v_nxt   = 1'b1;
                hit_idx_nxt = cmp_idx_r;
                hit_ent_nxt = rd_data_r;
              end
            end
            default: ;
          endcase
        end
        if (cmp_v_r && cmp_idx_r == SLOT_W'(TABLE_SLOTS - 1)) state_nxt = FSM_DONE;
      end

      FSM_DONE: begin
        state_nxt     = FSM_IDLE;
        out_valid_nxt = 1'b1;
        unique case (req_r.req_type)
          REQ_FIND_CREATE: begin
            if (hit_v_r) begin
              if (hit_ent_r.node_id != req_r.station_id && id_ok) begin
                wr_en = 1'b1;
                st    = ST_RENAMED;
              end
              out_nxt = '{status: st, slot: 4'(hit_idx_r),
                          result_id: (st == ST_RENAMED) ? req_r.station_id
                                                        : hit_ent_r.node_id,
                          result_mac: hit_ent_r.mac, active_count: 5'(total),
                          last: 1'b1};
            end else begin
              priority if (!id_ok) st = ST_BAD_ID;
              else if (taken_r) st = ST_ID_TAKEN;
              else if (!free_v) st = ST_FULL;
              else begin
                st        = ST_CREATED;
                wr_en     = 1'b1;
                wr_addr   = free_idx;
                wr_data   = '{node_id: req_r.station_id, mac: req_r.station_mac,
                              created: req_r.now_time};
                in_use_nxt[free_idx] = 1'b1;
              end
              out_nxt = '{status: st,
                          slot: (st == ST_CREATED) ? 4'(free_idx) : 4'd0,
                          result_id: req_r.station_id, result_mac: req_r.station_mac,
                          active_count: 5'(popcount(in_use_nxt)), last: 1'b1};
            end
          end
          REQ_FIND_ID: begin
            if (hit_v_r) begin
              out_nxt = '{status: ST_FOUND, slot: 4'(hit_idx_r),
                          result_id: hit_ent_r.node_id, result_mac: hit_ent_r.mac,
                          active_count: 5'(total), last: 1'b1};
            end else begin
              out_nxt = '{status: ST_NONE, slot: 4'd0, result_id: req_r.station_id,
                          result_mac: 48'd0, active_count: 5'(total), last: 1'b1};
            end
          end
          REQ_PRUNE: begin
            out_nxt = '{status: ST_PRUNE_DONE, slot: 4'd0, result_id: 8'd0,
                        result_mac: 48'd0, active_count: 5'(total), last: 1'b1};
          end
          REQ_LIST: begin
            if (total == '0) begin
              out_nxt = '{status: ST_LIST_EMPTY, slot: 4'd0, result_id: 8'd0,
                          result_mac: 48'd0, active_count: 5'(total), last: 1'b1};
            end else begin
              out_nxt = '{status: ST_LIST_ENTRY, slot: 4'(hit_idx_r),
                          result_id: hit_ent_r.node_id, result_mac: hit_ent_r.mac,
                          active_count: 5'(total),
                          last: (emitted_r + 1'b1 == total)};
              // Another selection pass finds the next key above this one.
              if (emitted_r + 1'b1 != total) begin
                state_nxt    = FSM_SCAN;
                emitted_nxt  = emitted_r + 1'b1;
                prev_v_nxt   = 1'b1;
                prev_key_nxt = best_key;
                hit_v_nxt    = 1'b0;
                rd_cnt_nxt   = '0;
              end
            end
          end
          default: ;
        endcase
      end

      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      in_use_r    <= '0;
      rd_cnt_r    <= '0;
      cmp_v_r     <= 1'b0;
      hit_v_r     <= 1'b0;
      taken_r     <= 1'b0;
      prev_v_r    <= 1'b0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
      timeout_r   <= 32'd10000;
      min_id_r    <= 8'd1;
      max_id_r    <= 8'd254;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      cmp_v_r     <= cmp_v_nxt;
      hit_v_r     <= hit_v_nxt;
      taken_r     <= taken_nxt;
      prev_v_r    <= prev_v_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_data;
          CFG_MIN_ID:  min_id_r  <= cfg_data[7:0];
          CFG_MAX_ID:  max_id_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    prev_key_r <= prev_key_nxt;
    out_r      <= out_nxt;
  end

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.last |-> !busy) else $error("last result while busy");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.last |-> busy) else $error("partial result while idle");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.active_count <= 5'(TABLE_SLOTS)) else $error("count range");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");

endmodule
